// File: design/baf_pkg.sv
// package: shared constants and register codes for the blended attractive force block
`default_nettype none
package baf_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int TANH_DEPTH_DEF = 1024;

	localparam int IN_W      = 12;
	localparam int FORCE_W   = 24;
	localparam int GAIN_W    = 24;
	localparam int RADIUS_W  = 12;
	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int S_DATA_W  = 2 * IN_W;
	localparam int M_DATA_W  = 2 * FORCE_W;
	localparam int M_USER_W  = 2;

	typedef enum logic [2:0] {
		REG_GOAL_X       = 3'd0,
		REG_GOAL_Y       = 3'd1,
		REG_QUAD_GAIN    = 3'd2,
		REG_SLOPE_GAIN   = 3'd3,
		REG_BLEND_RADIUS = 3'd4
	} reg_idx_t;

	localparam logic [IN_W-1:0]     GOAL_X_RST       = 12'd600;
	localparam logic [IN_W-1:0]     GOAL_Y_RST       = 12'd400;
	localparam logic [GAIN_W-1:0]   QUAD_GAIN_RST    = 24'd5243;
	localparam logic [GAIN_W-1:0]   SLOPE_GAIN_RST   = 24'd25600;
	localparam logic [RADIUS_W-1:0] BLEND_RADIUS_RST = 12'd50;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// floor(x/5) as (x * RECIP5_U) >> 30 for x below 2^30
	localparam logic [27:0] RECIP5_U = 28'd214748365;
	// floor(x/5) as (x * RECIP5_S) >> 15 for x below 2^14
	localparam logic [12:0] RECIP5_S = 13'd6554;

	localparam logic signed [FORCE_W-1:0] FORCE_MAX = 24'sh7fffff;
	localparam logic signed [FORCE_W-1:0] FORCE_MIN = 24'sh800000;

endpackage
`default_nettype wire

// File: design/blended_attractive_force.sv
// top level: pipelined attractive force with quadratic/linear tanh blend
//
// One grid point enters per cycle and one force result leaves per cycle once the pipe
// is full, as long as the output is not stalled. The pipe is a bit-per-stage square
// root of COORD_BITS+9 stages, eleven arithmetic stages, a 30-stage restoring divider
// for the distance normalization and the output register. The whole pipe advances
// together whenever the output register is empty or being taken, so an output stall
// holds every stage and the input. The tanh table is a constant ROM built at elaboration
// with one registered read per item. Registers are read live by the pipe and are to be
// written only while no item is in flight; the block itself does not enforce this.
`default_nettype none
module blended_attractive_force #(
	parameter int COORD_BITS       = baf_pkg::COORD_BITS_DEF,
	parameter int TANH_TABLE_DEPTH = baf_pkg::TANH_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [baf_pkg::APB_AW-1:0]    paddr,
	input  wire logic [baf_pkg::APB_DW-1:0]    pwdata,
	output logic      [baf_pkg::APB_DW-1:0]    prdata,
	output logic                               pready,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [baf_pkg::S_DATA_W-1:0]  s_tdata,  // point_x, point_y
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic      [baf_pkg::M_DATA_W-1:0]  m_tdata,  // force_x, force_y
	output logic      [baf_pkg::M_USER_W-1:0]  m_tuser   // at_goal, saturated
);
	import baf_pkg::*;

	localparam int CW   = (COORD_BITS < IN_W) ? COORD_BITS : IN_W;
	localparam int R    = CW + 9;
	localparam int D2W  = 2 * CW + 1;
	localparam int EMW  = (R > 20) ? R : 20;
	localparam int XW   = EMW + 5;
	localparam int UW   = EMW + 3;
	localparam int IXW  = $clog2(TANH_TABLE_DEPTH);
	localparam int IFW  = UW + IXW;
	localparam int PW   = EMW + 2;
	localparam int IW   = PW + 2;
	localparam int IMW  = PW + 1;
	localparam int QAW  = GAIN_W + 17;
	localparam int LAW  = GAIN_W + IMW;
	localparam int QW   = QAW + CW - 24;
	localparam int NW   = LAW + CW - 8;
	localparam int QB   = 30;
	localparam int SW   = ((QW > QB + 1) ? QW : QB + 1) + 2;

	typedef logic [16:0] tab_t [TANH_TABLE_DEPTH];

	typedef struct packed {
		logic          z;
		logic          dxneg;
		logic          dyneg;
		logic [CW-1:0] magx;
		logic [CW-1:0] magy;
	} geo_t;

	typedef struct packed {
		geo_t         g;
		logic [R-1:0] d;
	} mid_t;

	typedef struct packed {
		logic          z;
		logic          qxneg;
		logic          qyneg;
		logic          lxneg;
		logic          lyneg;
		logic          ovx;
		logic          ovy;
		logic [QW-1:0] qx;
		logic [QW-1:0] qy;
		logic [R-1:0]  d;
	} fwd_t;

	function automatic tab_t build_tab();
		tab_t        tb;
		logic [63:0] y;
		logic [63:0] dt;
		logic [63:0] sq;
		logic [63:0] rt;
		logic [63:0] ent;
		y  = '0;
		dt = (64'd1 << 26) / 64'(TANH_TABLE_DEPTH);
		for (int k = 0; k < TANH_TABLE_DEPTH; k++) begin
			ent   = (y + 64'd8192) >> 14;
			tb[k] = (ent > 64'(ONE_Q16)) ? ONE_Q16 : ent[16:0];
			for (int s = 0; s < 64; s++) begin
				sq = (y * y) >> 30;
				rt = (sq < (64'd1 << 30)) ? ((64'd1 << 30) - sq) : '0;
				y  = y + ((rt * dt) >> 30);
			end
		end
		return tb;
	endfunction

	localparam tab_t TANH_TAB = build_tab();

	// configuration registers
	logic [IN_W-1:0]     goal_x_q;
	logic [IN_W-1:0]     goal_y_q;
	logic [GAIN_W-1:0]   quad_gain_q;
	logic [GAIN_W-1:0]   slope_gain_q;
	logic [RADIUS_W-1:0] blend_radius_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q       <= GOAL_X_RST;
			goal_y_q       <= GOAL_Y_RST;
			quad_gain_q    <= QUAD_GAIN_RST;
			slope_gain_q   <= SLOPE_GAIN_RST;
			blend_radius_q <= BLEND_RADIUS_RST;
		end else if (wr_en) begin
			unique case (reg_idx_t'(paddr[4:2]))
				REG_GOAL_X:       goal_x_q       <= pwdata[IN_W-1:0];
				REG_GOAL_Y:       goal_y_q       <= pwdata[IN_W-1:0];
				REG_QUAD_GAIN:    quad_gain_q    <= pwdata[GAIN_W-1:0];
				REG_SLOPE_GAIN:   slope_gain_q   <= pwdata[GAIN_W-1:0];
				REG_BLEND_RADIUS: blend_radius_q <= pwdata[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[4:2]))
			REG_GOAL_X:       prdata = APB_DW'(goal_x_q);
			REG_GOAL_Y:       prdata = APB_DW'(goal_y_q);
			REG_QUAD_GAIN:    prdata = APB_DW'(quad_gain_q);
			REG_SLOPE_GAIN:   prdata = APB_DW'(slope_gain_q);
			REG_BLEND_RADIUS: prdata = APB_DW'(blend_radius_q);
			default:          prdata = '0;
		endcase
	end

	// pipe advance
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic sq_v_s [0:R];
	logic dv_v_s [0:QB];

	// stage 1: offsets from the goal
	logic signed [CW:0] dx_s1, dy_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= signed'({1'b0, s_tdata[CW-1:0]}) - signed'({1'b0, goal_x_q[CW-1:0]});
			dy_s1 <= signed'({1'b0, s_tdata[IN_W +: CW]}) - signed'({1'b0, goal_y_q[CW-1:0]});
		end
	end

	// stage 2: squared distance
	logic [CW:0]    ndx, ndy;
	logic [CW-1:0]  magx, magy;
	logic [D2W-1:0] d2;
	logic [D2W-1:0] d2_s2;
	geo_t           geo_s2;
	always_comb begin
		ndx  = -dx_s1;
		ndy  = -dy_s1;
		magx = dx_s1[CW] ? ndx[CW-1:0] : dx_s1[CW-1:0];
		magy = dy_s1[CW] ? ndy[CW-1:0] : dy_s1[CW-1:0];
		d2   = D2W'(magx * magx) + D2W'(magy * magy);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			d2_s2        <= d2;
			geo_s2.z     <= (d2 == '0);
			geo_s2.dxneg <= dx_s1[CW];
			geo_s2.dyneg <= dy_s1[CW];
			geo_s2.magx  <= magx;
			geo_s2.magy  <= magy;
		end
	end

	// square root of d2 * 2^16, one result bit per stage
	logic [R-1:0]   sq_root_s [0:R];
	logic [R:0]     sq_rem_s  [0:R];
	logic [2*R-1:0] sq_rad_s  [0:R];
	geo_t           sq_geo_s  [0:R];

	assign sq_root_s[0] = '0;
	assign sq_rem_s[0]  = '0;
	assign sq_rad_s[0]  = (2*R)'({d2_s2, 16'h0});
	assign sq_geo_s[0]  = geo_s2;
	assign sq_v_s[0]    = v_s2;

	for (genvar k = 0; k < R; k++) begin : g_sqrt
		logic [R+2:0] r2;
		logic [R+2:0] trial;
		logic         take;
		assign r2    = {sq_rem_s[k], sq_rad_s[k][2*R-1 -: 2]};
		assign trial = (R+3)'({sq_root_s[k], 2'b01});
		assign take  = (r2 >= trial);
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rad_s[k+1]  <= {sq_rad_s[k][2*R-3:0], 2'b00};
				sq_geo_s[k+1]  <= sq_geo_s[k];
				sq_root_s[k+1] <= {sq_root_s[k][R-2:0], take};
				sq_rem_s[k+1]  <= take ? (R+1)'(r2 - trial)
					: r2[R:0];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end
	end

	// stage 3: signed offset from the blend radius
	logic signed [EMW:0] e_w;
	logic [EMW:0]        ne_w;
	logic [EMW-1:0]      emag_s3;
	logic                eneg_s3;
	mid_t                mid_s3;
	always_comb begin
		e_w  = signed'((EMW+1)'(sq_root_s[R])) - signed'((EMW+1)'({blend_radius_q, 8'h0}));
		ne_w = -e_w;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			eneg_s3  <= e_w[EMW];
			emag_s3  <= e_w[EMW] ? ne_w[EMW-1:0] : e_w[EMW-1:0];
			mid_s3.g <= sq_geo_s[R];
			mid_s3.d <= sq_root_s[R];
		end
	end

	// stage 4: u = |e| * 256 / 40
	logic [XW+27:0] u_prod;
	logic [UW-1:0]  umag_s4;
	logic [EMW-1:0] emag_s4;
	logic           eneg_s4;
	mid_t           mid_s4;
	assign u_prod = (XW+28)'({emag_s3, 5'b0}) * (XW+28)'(RECIP5_U);
	always_ff @(posedge clk) begin
		if (adv) begin
			umag_s4 <= u_prod[30 +: UW];
			emag_s4 <= emag_s3;
			eneg_s4 <= eneg_s3;
			mid_s4  <= mid_s3;
		end
	end

	// stage 5: table lookup
	logic [IFW-1:0] idx_full;
	logic [16:0]    tab_s5;
	logic           over_s5;
	logic [EMW-1:0] emag_s5;
	logic           eneg_s5;
	mid_t           mid_s5;
	assign idx_full = (IFW'(umag_s4) * IFW'(TANH_TABLE_DEPTH)) >> 18;
	always_ff @(posedge clk) begin
		if (adv) begin
			tab_s5  <= TANH_TAB[idx_full[IXW-1:0]];
			over_s5 <= (idx_full >= IFW'(TANH_TABLE_DEPTH));
			emag_s5 <= emag_s4;
			eneg_s5 <= eneg_s4;
			mid_s5  <= mid_s4;
		end
	end

	// stage 6: t squared and blend
	logic [16:0]    tmag;
	logic [17:0]    bsum;
	logic [33:0]    tsq_s6;
	logic [16:0]    blend_s6;
	logic [EMW-1:0] emag_s6;
	logic           eneg_s6;
	mid_t           mid_s6;
	always_comb begin
		tmag = over_s5 ? ONE_Q16 : tab_s5;
		bsum = eneg_s5 ? (18'(ONE_Q16) - 18'(tmag)) : (18'(ONE_Q16) + 18'(tmag));
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			tsq_s6   <= 34'(tmag) * 34'(tmag);
			blend_s6 <= bsum[17:1];
			emag_s6  <= emag_s5;
			eneg_s6  <= eneg_s5;
			mid_s6   <= mid_s5;
		end
	end

	// stage 7: sigmoid slope (1 - t^2) / 80
	logic [16:0]    dn;
	logic [25:0]    ds_prod;
	logic [9:0]     dsig_s7;
	logic [16:0]    blend_s7;
	logic [EMW-1:0] emag_s7;
	logic           eneg_s7;
	mid_t           mid_s7;
	always_comb begin
		dn      = ONE_Q16 - tsq_s6[32:16];
		ds_prod = 26'(dn[16:4]) * 26'(RECIP5_S);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			dsig_s7  <= ds_prod[24:15];
			blend_s7 <= blend_s6;
			emag_s7  <= emag_s6;
			eneg_s7  <= eneg_s6;
			mid_s7   <= mid_s6;
		end
	end

	// stage 8: inner factor
	logic [EMW+9:0]       p_prod;
	logic signed [IW-1:0] inner;
	logic [IW-1:0]        ninner;
	logic [IMW-1:0]       imag_s8;
	logic                 ineg_s8;
	logic [16:0]          qb_s8;
	mid_t                 mid_s8;
	always_comb begin
		p_prod = (EMW+10)'(dsig_s7) * (EMW+10)'(emag_s7);
		inner  = eneg_s7 ? (signed'(IW'(blend_s7)) - signed'(IW'(p_prod[EMW+9:8])))
			: (signed'(IW'(blend_s7)) + signed'(IW'(p_prod[EMW+9:8])));
		ninner = -inner;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ineg_s8 <= inner[IW-1];
			imag_s8 <= inner[IW-1] ? ninner[IMW-1:0] : inner[IMW-1:0];
			qb_s8   <= ONE_Q16 - blend_s7;
			mid_s8  <= mid_s7;
		end
	end

	// stage 9: gain products
	logic [QAW-1:0] qa_s9;
	logic [LAW-1:0] la_s9;
	logic           ineg_s9;
	mid_t           mid_s9;
	always_ff @(posedge clk) begin
		if (adv) begin
			qa_s9   <= QAW'(quad_gain_q) * QAW'(qb_s8);
			la_s9   <= LAW'(slope_gain_q) * LAW'(imag_s8);
			ineg_s9 <= ineg_s8;
			mid_s9  <= mid_s8;
		end
	end

	// stage 10: per component terms
	logic [QAW+CW-1:0] qpx, qpy;
	logic [LAW+CW-1:0] npx, npy;
	logic [QW-1:0]     qx_s10, qy_s10;
	logic [NW-1:0]     nx_s10, ny_s10;
	logic              ineg_s10;
	mid_t              mid_s10;
	always_comb begin
		qpx = (QAW+CW)'(qa_s9) * (QAW+CW)'(mid_s9.g.magx);
		qpy = (QAW+CW)'(qa_s9) * (QAW+CW)'(mid_s9.g.magy);
		npx = (LAW+CW)'(la_s9) * (LAW+CW)'(mid_s9.g.magx);
		npy = (LAW+CW)'(la_s9) * (LAW+CW)'(mid_s9.g.magy);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s10   <= qpx[QAW+CW-1:24];
			qy_s10   <= qpy[QAW+CW-1:24];
			nx_s10   <= npx[LAW+CW-1:8];
			ny_s10   <= npy[LAW+CW-1:8];
			ineg_s10 <= ineg_s9;
			mid_s10  <= mid_s9;
		end
	end

	// restoring divider by d, one quotient bit per stage; stage 0 checks range
	logic [R-1:0]  dv_rx_s [0:QB];
	logic [R-1:0]  dv_ry_s [0:QB];
	logic [QB-1:0] dv_nx_s [0:QB];
	logic [QB-1:0] dv_ny_s [0:QB];
	logic [QB-1:0] dv_qx_s [0:QB];
	logic [QB-1:0] dv_qy_s [0:QB];
	fwd_t          dv_fw_s [0:QB];

	logic [NW-QB-1:0] hix, hiy;
	assign hix = nx_s10[NW-1:QB];
	assign hiy = ny_s10[NW-1:QB];

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_rx_s[0]       <= hix[R-1:0];
			dv_ry_s[0]       <= hiy[R-1:0];
			dv_nx_s[0]       <= nx_s10[QB-1:0];
			dv_ny_s[0]       <= ny_s10[QB-1:0];
			dv_qx_s[0]       <= '0;
			dv_qy_s[0]       <= '0;
			dv_fw_s[0].z     <= mid_s10.g.z;
			dv_fw_s[0].qxneg <= mid_s10.g.dxneg;
			dv_fw_s[0].qyneg <= mid_s10.g.dyneg;
			dv_fw_s[0].lxneg <= mid_s10.g.dxneg ^ ineg_s10;
			dv_fw_s[0].lyneg <= mid_s10.g.dyneg ^ ineg_s10;
			dv_fw_s[0].ovx   <= (hix >= (NW-QB)'(mid_s10.d));
			dv_fw_s[0].ovy   <= (hiy >= (NW-QB)'(mid_s10.d));
			dv_fw_s[0].qx    <= qx_s10;
			dv_fw_s[0].qy    <= qy_s10;
			dv_fw_s[0].d     <= mid_s10.d;
		end
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [R:0] rx2, ry2;
		logic       tx, ty;
		assign rx2 = {dv_rx_s[j], dv_nx_s[j][QB-1]};
		assign ry2 = {dv_ry_s[j], dv_ny_s[j][QB-1]};
		assign tx  = (rx2 >= (R+1)'(dv_fw_s[j].d));
		assign ty  = (ry2 >= (R+1)'(dv_fw_s[j].d));
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rx_s[j+1] <= tx ? R'(rx2 - (R+1)'(dv_fw_s[j].d)) : rx2[R-1:0];
				dv_ry_s[j+1] <= ty ? R'(ry2 - (R+1)'(dv_fw_s[j].d)) : ry2[R-1:0];
				dv_nx_s[j+1] <= {dv_nx_s[j][QB-2:0], 1'b0};
				dv_ny_s[j+1] <= {dv_ny_s[j][QB-2:0], 1'b0};
				dv_qx_s[j+1] <= {dv_qx_s[j][QB-2:0], tx};
				dv_qy_s[j+1] <= {dv_qy_s[j][QB-2:0], ty};
				dv_fw_s[j+1] <= dv_fw_s[j];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end
	end

	// output stage: combine, negate, saturate
	fwd_t                 fw;
	logic signed [SW-1:0] qvx, qvy, lvx, lvy, fsx, fsy;
	logic                 satx, saty;
	logic [FORCE_W-1:0]   fx, fy;
	localparam logic signed [SW-1:0] SMAX = SW'(FORCE_MAX);
	localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
	always_comb begin
		fw   = dv_fw_s[QB];
		qvx  = fw.qxneg ? -signed'(SW'(fw.qx)) : signed'(SW'(fw.qx));
		qvy  = fw.qyneg ? -signed'(SW'(fw.qy)) : signed'(SW'(fw.qy));
		lvx  = fw.ovx ? signed'(SW'(2**QB)) : signed'(SW'(dv_qx_s[QB]));
		lvy  = fw.ovy ? signed'(SW'(2**QB)) : signed'(SW'(dv_qy_s[QB]));
		lvx  = fw.lxneg ? -lvx : lvx;
		lvy  = fw.lyneg ? -lvy : lvy;
		fsx  = -(qvx + lvx);
		fsy  = -(qvy + lvy);
		satx = (fsx > SMAX) || (fsx < SMIN);
		saty = (fsy > SMAX) || (fsy < SMIN);
		fx   = satx ? (fsx[SW-1] ? FORCE_MIN : FORCE_MAX) : fsx[FORCE_W-1:0];
		fy   = saty ? (fsy[SW-1] ? FORCE_MIN : FORCE_MAX) : fsy[FORCE_W-1:0];
	end

	logic [FORCE_W-1:0] fx_s12, fy_s12;
	logic               at_goal_s12, sat_s12;
	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s12      <= fw.z ? '0 : fx;
			fy_s12      <= fw.z ? '0 : fy;
			at_goal_s12 <= fw.z;
			sat_s12     <= !fw.z && (satx || saty);
		end
	end

	assign m_tdata = {fy_s12, fx_s12};
	assign m_tuser = {sat_s12, at_goal_s12};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			v_s7      <= 1'b0;
			v_s8      <= 1'b0;
			v_s9      <= 1'b0;
			v_s10     <= 1'b0;
			dv_v_s[0] <= 1'b0;
			m_tvalid  <= 1'b0;
		end else if (adv) begin
			v_s1      <= s_tvalid;
			v_s2      <= v_s1;
			v_s3      <= sq_v_s[R];
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			v_s7      <= v_s6;
			v_s8      <= v_s7;
			v_s9      <= v_s8;
			v_s10     <= v_s9;
			dv_v_s[0] <= v_s10;
			m_tvalid  <= dv_v_s[QB];
		end
	end

endmodule
`default_nettype wire

// File: tb/blended_attractive_force_tb.sv
// testbench: stream and register-port checks of the blended attractive force block
`timescale 1ns / 1ps
`default_nettype none
module blended_attractive_force_tb;
	import baf_pkg::*;

	localparam int TAB_DEPTH = 1024;
	localparam int CBITS = 12;
	localparam int LAT = CBITS + 51;
	localparam logic [APB_AW-1:0] UNUSED_REG_ADDR = 5'd28;

	typedef struct packed {
		logic signed [FORCE_W-1:0] fx;
		logic signed [FORCE_W-1:0] fy;
		logic at_goal;
		logic sat;
	} force_t;

	typedef struct {
		logic [IN_W-1:0] x;
		logic [IN_W-1:0] y;
		bit known;
		force_t res;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;  // point_x, point_y
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;  // force_x, force_y
	logic [M_USER_W-1:0] m_tuser;  // at_goal, saturated

	blended_attractive_force u_top (.*);

	always #6 clk = ~clk;

	longint unsigned tanh_rom [TAB_DEPTH];
	longint unsigned goal_x_q, goal_y_q, quad_gain_q, slope_gain_q, radius_q;
	force_t force_q [$];
	bit next_known;
	force_t next_res;
	int errors = 0;
	int n_items = 0, n_results = 0, n_sat = 0, n_goal = 0;
	bit burst = 0;

	function automatic void build_tanh_rom();
		longint unsigned y, dt, sq, rate;
		y = 0;
		dt = (64'd1 << 26) / TAB_DEPTH;
		for (int k = 0; k < TAB_DEPTH; k++) begin
			tanh_rom[k] = (y + (64'd1 << 13)) >> 14;
			if (tanh_rom[k] > 65536) tanh_rom[k] = 65536;
			for (int s = 0; s < 64; s++) begin
				sq = (y * y) >> 30;
				rate = (sq < (64'd1 << 30)) ? ((64'd1 << 30) - sq) : 0;
				y += (rate * dt) >> 30;
			end
		end
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [FORCE_W-1:0] axis_force(longint delta,
			longint unsigned blend, longint inner, longint unsigned d_q8, ref logic sat);
		longint unsigned mag, imag;
		longint quad, lin, f;
		mag = delta < 0 ? -delta : delta;
		imag = inner < 0 ? -inner : inner;
		quad = (quad_gain_q * (65536 - blend) * mag) >> 24;
		lin = (slope_gain_q * imag * mag) / (d_q8 * 256);
		if (delta < 0) quad = -quad;
		if ((delta < 0) != (inner < 0)) lin = -lin;
		f = -(quad + lin);
		if (f > 8388607) begin
			sat = 1'b1;
			return FORCE_MAX;
		end
		if (f < -8388608) begin
			sat = 1'b1;
			return FORCE_MIN;
		end
		return f[FORCE_W-1:0];
	endfunction

	function automatic force_t attract_force(logic [IN_W-1:0] px, logic [IN_W-1:0] py);
		force_t r;
		longint dx, dy, e, t, inner;
		longint unsigned d2, d_q8, emag, umag, idx, tmag, blend, dsig;
		logic sat;
		r = '0;
		sat = 1'b0;
		dx = longint'(px) - longint'(goal_x_q);
		dy = longint'(py) - longint'(goal_y_q);
		d2 = dx * dx + dy * dy;
		if (d2 == 0) begin
			r.at_goal = 1'b1;
			return r;
		end
		d_q8 = int_sqrt(d2 << 16);
		e = longint'(d_q8) - longint'(radius_q * 256);
		emag = e < 0 ? -e : e;
		umag = (emag * 256) / 40;
		idx = (umag * TAB_DEPTH) >> 18;
		tmag = idx < TAB_DEPTH ? tanh_rom[idx] : 65536;
		t = e < 0 ? -longint'(tmag) : longint'(tmag);
		blend = (t + 65536) / 2;
		dsig = (65536 - ((tmag * tmag) >> 16)) / 80;
		inner = (dsig * emag) >> 8;
		if (e < 0) inner = -inner;
		inner += blend;
		r.fx = axis_force(dx, blend, inner, d_q8, sat);
		r.fy = axis_force(dy, blend, inner, d_q8, sat);
		r.sat = sat;
		return r;
	endfunction

	// scoreboard
	always @(posedge clk) begin
		force_t want, got;
		if (s_tvalid && s_tready) begin
			force_q.push_back(next_known ? next_res :
				attract_force(s_tdata[IN_W-1:0], s_tdata[2*IN_W-1:IN_W]));
			n_items++;
		end
		if (m_tvalid && m_tready) begin
			got.fx = m_tdata[FORCE_W-1:0];
			got.fy = m_tdata[2*FORCE_W-1:FORCE_W];
			got.at_goal = m_tuser[0];
			got.sat = m_tuser[1];
			n_results++;
			if (got.sat) n_sat++;
			if (got.at_goal) n_goal++;
			if (force_q.size() == 0) begin
				$display("%t: unexpected result fx=%0d fy=%0d", $realtime, got.fx, got.fy);
				errors++;
			end else begin
				want = force_q.pop_front();
				if (got !== want) begin
					$display("%t: mismatch expected fx=%0d fy=%0d goal=%b sat=%b, actual fx=%0d fy=%0d goal=%b sat=%b",
						$realtime, want.fx, want.fy, want.at_goal, want.sat,
						got.fx, got.fy, got.at_goal, got.sat);
					errors++;
				end
			end
		end
	end

	// result side stalls
	initial begin
		int gap;
		forever begin
			gap = burst ? 0 : $urandom_range(0, 17);
			if (gap > 0) begin
				m_tready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	task automatic send_point(logic [IN_W-1:0] px, logic [IN_W-1:0] py, bit known, force_t res);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		next_known = known;
		next_res = res;
		s_tdata = {py, px};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 1'b0;
		while (force_q.size() != 0) @(negedge clk);
		repeat (LAT + 10) @(negedge clk);
	endtask

	task automatic reg_access(logic [APB_AW-1:0] addr, logic wr, logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		psel = 1'b1;
		pwrite = wr;
		paddr = addr;
		pwdata = wdata;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic write_reg(reg_idx_t idx, longint unsigned val);
		logic [APB_DW-1:0] rd;
		reg_access(APB_AW'(idx) << 2, 1'b1, APB_DW'(val), rd);
		case (idx)
			REG_GOAL_X: goal_x_q = val & 12'hfff;
			REG_GOAL_Y: goal_y_q = val & 12'hfff;
			REG_QUAD_GAIN: quad_gain_q = val & 24'hffffff;
			REG_SLOPE_GAIN: slope_gain_q = val & 24'hffffff;
			REG_BLEND_RADIUS: radius_q = val & 12'hfff;
			default: ;
		endcase
	endtask

	task automatic check_regs();
		logic [APB_DW-1:0] rd;
		longint unsigned want [5];
		want = '{goal_x_q, goal_y_q, quad_gain_q, slope_gain_q, radius_q};
		for (int i = 0; i < 5; i++) begin
			reg_access(APB_AW'(i) << 2, 1'b0, '0, rd);
			if (rd !== APB_DW'(want[i])) begin
				$display("%t: register %0d expected %0d actual %0d", $realtime, i, want[i], rd);
				errors++;
			end
		end
	endtask

	task automatic set_all(longint unsigned gx, longint unsigned gy, longint unsigned qg,
			longint unsigned sg, longint unsigned rad);
		write_reg(REG_GOAL_X, gx);
		write_reg(REG_GOAL_Y, gy);
		write_reg(REG_QUAD_GAIN, qg);
		write_reg(REG_SLOPE_GAIN, sg);
		write_reg(REG_BLEND_RADIUS, rad);
		check_regs();
	endtask

	function automatic logic [IN_W-1:0] near(longint unsigned c, int span);
		int v;
		v = int'(c) + $urandom_range(0, 2 * span) - span;
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v[IN_W-1:0];
	endfunction

	task automatic random_points(int n);
		int span;
		for (int i = 0; i < n; i++) begin
			if (($urandom_range(0, 99) == 0)) burst = ~burst;
			case ($urandom_range(0, 9))
				0, 1, 2: send_point(IN_W'($urandom), IN_W'($urandom), 0, '0);
				3: send_point(goal_x_q[IN_W-1:0], goal_y_q[IN_W-1:0], 0, '0);
				default: begin
					span = $urandom_range(0, 1) ? 4 : int'(radius_q) + 250;
					send_point(near(goal_x_q, span), near(goal_y_q, span), 0, '0);
				end
			endcase
		end
		burst = 0;
	endtask

	point_row_t plan [] = '{
		'{12'd600, 12'd400, 1, '{24'sd0, 24'sd0, 1'b1, 1'b0}},
		'{12'd0, 12'd0, 0, '0},
		'{12'd4095, 12'd4095, 0, '0},
		'{12'd4095, 12'd0, 0, '0},
		'{12'd0, 12'd4095, 0, '0},
		'{12'd601, 12'd400, 0, '0},
		'{12'd599, 12'd400, 0, '0},
		'{12'd600, 12'd401, 0, '0},
		'{12'd600, 12'd399, 0, '0},
		'{12'd650, 12'd400, 0, '0},
		'{12'd640, 12'd430, 0, '0},
		'{12'd700, 12'd400, 0, '0},
		'{12'd760, 12'd400, 0, '0},
		'{12'd1000, 12'd700, 0, '0},
		'{12'd2730, 12'd1365, 0, '0},
		'{12'd2048, 12'd2048, 0, '0}
	};

	point_row_t plan_extreme [] = '{
		'{12'd0, 12'd0, 1, '{24'sd0, 24'sd0, 1'b1, 1'b0}},
		'{12'd4095, 12'd4095, 1, '{FORCE_MIN, FORCE_MIN, 1'b0, 1'b1}},
		'{12'd4095, 12'd0, 1, '{FORCE_MIN, 24'sd0, 1'b0, 1'b1}},
		'{12'd1, 12'd0, 0, '0},
		'{12'd0, 12'd1, 0, '0}
	};

	initial begin
		logic [APB_DW-1:0] rd;
		build_tanh_rom();
		goal_x_q = GOAL_X_RST;
		goal_y_q = GOAL_Y_RST;
		quad_gain_q = QUAD_GAIN_RST;
		slope_gain_q = SLOPE_GAIN_RST;
		radius_q = BLEND_RADIUS_RST;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		check_regs();

		foreach (plan[i]) send_point(plan[i].x, plan[i].y, plan[i].known, plan[i].res);
		drain();
		random_points(260);
		drain();

		// write to an unused address must leave every register alone
		reg_access(UNUSED_REG_ADDR, 1'b1, 32'hffffffff, rd);
		check_regs();

		set_all(0, 0, 24'hffffff, 24'hffffff, 12'hfff);
		foreach (plan_extreme[i])
			send_point(plan_extreme[i].x, plan_extreme[i].y, plan_extreme[i].known,
				plan_extreme[i].res);
		random_points(150);
		drain();

		set_all(4095, 4095, 0, 0, 0);
		send_point(12'd0, 12'd0, 1, '{24'sd0, 24'sd0, 1'b0, 1'b0});
		send_point(12'd4095, 12'd4095, 1, '{24'sd0, 24'sd0, 1'b1, 1'b0});
		random_points(100);
		drain();

		set_all(2048, 1024, 5243, 25600, 0);
		random_points(200);
		drain();

		for (int p = 0; p < 4; p++) begin
			set_all($urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 1) ? $urandom_range(0, 24'hffffff) : $urandom_range(0, 65535),
				$urandom_range(0, 1) ? $urandom_range(0, 24'hffffff) : $urandom_range(0, 65535),
				$urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom_range(0, 200));
			random_points(150);
			drain();
		end

		$display("covered %0d points and %0d results (%0d at goal, %0d clipped)",
			n_items, n_results, n_goal, n_sat);
		$display("over eight register settings including all-zero and all-max gains");
		if (errors == 0 && force_q.size() == 0) begin
			$display("** blended_attractive_force: PASSED **");
		end else begin
			$display("** blended_attractive_force: FAILED **");
		end
		$finish;
	end

	initial begin
		#8ms;
		$display("timeout");
		$display("** blended_attractive_force: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
design/baf_pkg.sv
design/blended_attractive_force.sv
tb/blended_attractive_force_tb.sv
